// ===== design/utf8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types, constants and lead-byte decode functions for the UTF-8
// stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int unsigned CP_W = 21;
  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP         = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;
  localparam logic [5:0]      CONT_MASK      = 6'h3F;

  typedef logic [2:0] width_t;

  typedef struct packed {
    logic [1:0] bytes_left;
    logic       swallowing;
  } ctl_t;

  // Sequence width from the lead byte; zero for bytes that cannot lead.
  function automatic width_t lead_width(input logic [7:0] b);
    width_t w;
    priority if (b <= 8'h7F) w = 3'd1;
    else if (b <  8'hC2) w = 3'd0;
    else if (b <= 8'hDF) w = 3'd2;
    else if (b <= 8'hEF) w = 3'd3;
    else if (b <= 8'hF4) w = 3'd4;
    else                 w = 3'd0;
    return w;
  endfunction

  function automatic logic [6:0] lead_mask(input width_t w);
    logic [6:0] m;
    unique case (w)
      3'd1:    m = 7'h7F;
      3'd2:    m = 7'h1F;
      3'd3:    m = 7'h0F;
      default: m = 7'h07;
    endcase
    return m;
  endfunction

  // Surrogates and out-of-range values become the replacement character.
  function automatic logic [CP_W-1:0] checked(input logic [CP_W-1:0] v);
    logic [CP_W-1:0] r;
    if ((v >= SURR_LO && v <= SURR_HI) || v > MAX_CP) r = REPLACEMENT_CP;
    else r = v;
    return r;
  endfunction

endpackage

// ===== design/utf8sd_step.sv =====
// ----------------------------------------------------------------------------
// utf8sd_step
// Combinational decode of one byte against the current sequence state:
// next state, result flag and code point.
// ----------------------------------------------------------------------------
module utf8sd_step #(
  parameter int unsigned MAX_WIDTH = 3,
  parameter int unsigned ACC_W     = 5 * MAX_WIDTH + 1
) (
  input  utf8sd_pkg::ctl_t            ctl,
  input  logic [ACC_W-1:0]            acc,
  input  logic [7:0]                  byte_in,
  input  logic                        last_in,
  output utf8sd_pkg::ctl_t            ctl_nxt,
  output logic [ACC_W-1:0]            acc_nxt,
  output logic                        emit,
  output logic [utf8sd_pkg::CP_W-1:0] cp
);

  localparam int unsigned CP_W = utf8sd_pkg::CP_W;

  utf8sd_pkg::width_t w;
  logic [1:0]         bl_dec;
  logic [ACC_W-1:0]   acc_shift;
  logic [ACC_W-1:0]   acc_lead;
  logic [CP_W-1:0]    cp_raw;
  logic               use_check;

  assign w         = utf8sd_pkg::lead_width(byte_in);
  assign bl_dec    = ctl.bytes_left - 2'd1;
  assign acc_shift = ACC_W'({acc, byte_in[5:0] & utf8sd_pkg::CONT_MASK});
  assign acc_lead  = ACC_W'(byte_in[6:0] & utf8sd_pkg::lead_mask(w));

  always_comb begin
    ctl_nxt   = ctl;
    acc_nxt   = acc;
    emit      = 1'b0;
    use_check = 1'b0;
    cp_raw    = utf8sd_pkg::REPLACEMENT_CP;
    if (ctl.bytes_left != 2'd0) begin
      ctl_nxt.bytes_left = bl_dec;
      emit = (bl_dec == 2'd0) || last_in;
      if (!ctl.swallowing) begin
        acc_nxt   = acc_shift;
        use_check = 1'b1;
        cp_raw    = CP_W'(acc_shift);
      end
    end else if (w == 3'd0) begin
      emit = 1'b1;
    end else if (32'(w) > MAX_WIDTH) begin
      if (last_in) begin
        emit = 1'b1;
      end else begin
        ctl_nxt.bytes_left = 2'(w - 3'd1);
        ctl_nxt.swallowing = 1'b1;
        acc_nxt            = '0;
      end
    end else begin
      acc_nxt   = acc_lead;
      use_check = 1'b1;
      cp_raw    = CP_W'(acc_lead);
      if (w == 3'd1 || last_in) begin
        emit = 1'b1;
      end else begin
        ctl_nxt.bytes_left = 2'(w - 3'd1);
        ctl_nxt.swallowing = 1'b0;
      end
    end
    // a finished sequence clears the state
    if (emit) begin
      ctl_nxt = '0;
      acc_nxt = '0;
    end
  end

  assign cp = use_check ? utf8sd_pkg::checked(cp_raw) : utf8sd_pkg::REPLACEMENT_CP;

endmodule

// ===== design/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code points. One byte is taken per cycle, with no
// bubbles, unless a finished sequence waits on a full result register: a
// byte lands in the input register, is decoded in the next cycle against the
// sequence state and, when it completes a sequence or ends the string,
// writes the result register. Throughput is one byte per cycle under the same
// condition, set by the single decode step between the input and result
// registers. Bytes that cannot lead, surrogates and values above U+10FFFF
// yield U+FFFD; a string that ends mid-sequence yields the partial value.
// MAX_WIDTH (3 or 4) is the longest sequence decoded; longer ones yield U+FFFD.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
  parameter int unsigned MAX_WIDTH = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [utf8sd_pkg::CP_W-1:0] out_code_point,
  output logic                        out_last
);

  localparam int unsigned ACC_W = 5 * MAX_WIDTH + 1;
  localparam int unsigned CP_W  = utf8sd_pkg::CP_W;

  logic             s0_valid_r;
  logic [7:0]       s0_byte_r;
  logic             s0_last_r;

  utf8sd_pkg::ctl_t ctl_r, ctl_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             emit;
  logic [CP_W-1:0]  cp;

  logic             out_valid_r;
  logic [CP_W-1:0]  cp_r;
  logic             out_last_r;

  logic             out_free;
  logic             s0_adv;

  utf8sd_step #(
    .MAX_WIDTH (MAX_WIDTH),
    .ACC_W     (ACC_W)
  ) u_step (
    .ctl     (ctl_r),
    .acc     (acc_r),
    .byte_in (s0_byte_r),
    .last_in (s0_last_r),
    .ctl_nxt (ctl_nxt),
    .acc_nxt (acc_nxt),
    .emit    (emit),
    .cp      (cp)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s0_adv   = s0_valid_r && (!emit || out_free);
  assign in_ready = !s0_valid_r || s0_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      ctl_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s0_valid_r <= in_valid;
      end
      if (s0_adv) begin
        ctl_r <= ctl_nxt;
        acc_r <= acc_nxt;
      end
      if (s0_adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_byte_r <= in_byte;
      s0_last_r <= in_last;
    end
    if (s0_adv && emit) begin
      cp_r       <= cp;
      out_last_r <= s0_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = cp_r;
  assign out_last       = out_last_r;

endmodule

// ===== design/utf8sd_checker.sv =====
// ----------------------------------------------------------------------------
// utf8sd_checker
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8sd_checker #(
  parameter int unsigned MAX_WIDTH = 3
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [7:0]                  in_byte,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [utf8sd_pkg::CP_W-1:0] out_code_point,
  input logic                        out_last
);

  // stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("request changed while stalled");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point) && $stable(out_last))
    else $error("result changed while stalled");

  // never a surrogate or out-of-range value
  a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_code_point >= utf8sd_pkg::SURR_LO &&
                    out_code_point <= utf8sd_pkg::SURR_HI) &&
                  out_code_point <= utf8sd_pkg::MAX_CP)
    else $error("code point out of range");

  // three-byte limit keeps results in the BMP
  a_bmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && MAX_WIDTH == 3 |-> out_code_point <= 21'h00FFFF)
    else $error("code point above BMP with three-byte limit");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind utf8_stream_decoder utf8sd_checker #(
  .MAX_WIDTH (MAX_WIDTH)
) u_utf8sd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_byte        (in_byte),
  .in_last        (in_last),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_code_point (out_code_point),
  .out_last       (out_last)
);
